// ===== hw/rtl/base64_codec_macros.svh =====
// Assertion macros used by the base64 codec RTL.
`ifndef BASE64_CODEC_MACROS_SVH
`define BASE64_CODEC_MACROS_SVH

// Check a property on a given clock, masked while the given reset is low.
`define B64_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on the block clock and reset.
`define B64_ASSERT(lbl, prop, msg) \
  `B64_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hw/rtl/b64_pkg.sv =====
// Shared types, constants and character tables of the base64 codec.
`default_nettype none

package b64_pkg;

  // Default queue depths (powers of two)
  localparam int unsigned JOB_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 4;

  // Register word index taken from the address
  localparam logic REG_DIRECTION = 1'b0;

  // Character codes
  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // Sextet codes beyond the 64 alphabet values
  localparam logic [6:0] SEXTET_SKIP = 7'd64;
  localparam logic [6:0] SEXTET_BAD  = 7'd65;

  typedef enum logic {
    DIR_ENC = 1'b0,
    DIR_DEC = 1'b1
  } dir_e;

  typedef enum logic [1:0] {
    JOB_ENC,   // one encode group: four characters
    JOB_DATA,  // one decoded byte
    JOB_END,   // bare end marker
    JOB_ERR    // invalid character marker
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [23:0] group;   // encode group, first byte high; decoded byte in [7:0]
    logic [1:0]  nbytes;  // bytes in an encode group, 1..3
    logic        last;
  } job_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       bad_char;
    logic       last;
  } res_t;

  // Map a 6-bit value onto its alphabet character
  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] c;
    if (idx < 6'd26) begin
      c = 8'h41 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      c = 8'h61 + {2'b00, idx} - 8'd26;
    end else if (idx < 6'd62) begin
      c = 8'h30 + {2'b00, idx} - 8'd52;
    end else if (idx == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

  // Map a character onto its 6-bit value, or the skip or bad code
  function automatic logic [6:0] b64_sextet(input logic [7:0] c);
    logic [6:0] v;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == CHAR_PLUS) begin
      v = 7'd62;
    end else if (c == CHAR_SLASH) begin
      v = 7'd63;
    end else if (c == CHAR_CR || c == CHAR_LF || c == CHAR_SPACE || c == CHAR_PAD) begin
      v = SEXTET_SKIP;
    end else begin
      v = SEXTET_BAD;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64_fifo.sv =====
// Small first-word-fall-through queue used between the codec stages.
`default_nettype none

module b64_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW:0]    wptr_q, wptr_d;
  logic [PtrW:0]    rptr_q, rptr_d;
  logic             do_push, do_pop;

  // Flag full when pointers differ only in the wrap bit
  assign empty_o = (wptr_q == rptr_q);
  assign full_o  = (wptr_q[PtrW] != rptr_q[PtrW]) &&
                   (wptr_q[PtrW-1:0] == rptr_q[PtrW-1:0]);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q[PtrW-1:0]];

  // Advance pointers on each beat
  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop  ? rptr_q + 1'b1 : rptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q[PtrW-1:0]] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/b64_front.sv =====
// Front stage: takes input beats, tracks codec state and issues jobs.
`default_nettype none

module b64_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  input  b64_pkg::dir_e   dir_i,
  output logic            job_valid_o,
  output b64_pkg::job_t   job_o
);
  import b64_pkg::*;

  logic [15:0] enc_hold_q, enc_hold_d;
  logic [1:0]  enc_cnt_q, enc_cnt_d;
  logic [12:0] dec_acc_q, dec_acc_d;
  logic [2:0]  dec_bits_q, dec_bits_d;
  logic        skip_q, skip_d;

  logic [6:0]  sx;
  logic [3:0]  bits_sum;
  logic [12:0] acc_new;
  logic [7:0]  dec_byte;

  // Classify the character and extend the accumulator
  always_comb begin
    sx       = b64_sextet(in_byte_i);
    bits_sum = {1'b0, dec_bits_q} + 4'd6;
    acc_new  = {dec_acc_q[6:0], sx[5:0]};
    case (bits_sum[2:0])
      3'd2:    dec_byte = acc_new[9:2];
      3'd4:    dec_byte = acc_new[11:4];
      default: dec_byte = acc_new[7:0];
    endcase
  end

  // Update state and form the job for this beat
  always_comb begin
    enc_hold_d  = enc_hold_q;
    enc_cnt_d   = enc_cnt_q;
    dec_acc_d   = dec_acc_q;
    dec_bits_d  = dec_bits_q;
    skip_d      = skip_q;
    job_valid_o = 1'b0;
    job_o.kind   = JOB_END;
    job_o.group  = '0;
    job_o.nbytes = '0;
    job_o.last   = in_last_i;

    if (valid_i) begin
      if (dir_i == DIR_ENC) begin
        if (!in_last_i && enc_cnt_q < 2'd2) begin
          enc_hold_d = {enc_hold_q[7:0], in_byte_i};
          enc_cnt_d  = enc_cnt_q + 2'd1;
        end else begin
          job_valid_o  = 1'b1;
          job_o.kind   = JOB_ENC;
          job_o.nbytes = enc_cnt_q + 2'd1;
          case (enc_cnt_q)
            2'd0:    job_o.group = {in_byte_i, 16'h0000};
            2'd1:    job_o.group = {enc_hold_q[7:0], in_byte_i, 8'h00};
            default: job_o.group = {enc_hold_q, in_byte_i};
          endcase
          enc_hold_d = '0;
          enc_cnt_d  = '0;
          if (in_last_i) begin
            skip_d = 1'b0;
          end
        end
      end else if (skip_q) begin
        // Drop beats until the end of the message
        if (in_last_i) begin
          skip_d = 1'b0;
        end
      end else if (sx == SEXTET_BAD) begin
        job_valid_o = 1'b1;
        job_o.kind  = JOB_ERR;
        job_o.last  = 1'b1;
        dec_acc_d   = '0;
        dec_bits_d  = '0;
        skip_d      = !in_last_i;
      end else if (sx != SEXTET_SKIP && bits_sum >= 4'd8) begin
        job_valid_o       = 1'b1;
        job_o.kind        = JOB_DATA;
        job_o.group[7:0]  = dec_byte;
        dec_acc_d         = in_last_i ? '0 : acc_new;
        dec_bits_d        = in_last_i ? '0 : bits_sum[2:0];
      end else begin
        if (sx != SEXTET_SKIP) begin
          dec_acc_d  = acc_new;
          dec_bits_d = bits_sum[2:0];
        end
        if (in_last_i) begin
          job_valid_o = 1'b1;
          job_o.kind  = JOB_END;
          dec_acc_d   = '0;
          dec_bits_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_hold_q <= '0;
      enc_cnt_q  <= '0;
      dec_acc_q  <= '0;
      dec_bits_q <= '0;
      skip_q     <= 1'b0;
    end else begin
      enc_hold_q <= enc_hold_d;
      enc_cnt_q  <= enc_cnt_d;
      dec_acc_q  <= dec_acc_d;
      dec_bits_q <= dec_bits_d;
      skip_q     <= skip_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/b64_back.sv =====
// Back stage: expands each job into result beats, one per cycle while the result queue has room.
`default_nettype none

module b64_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  b64_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          res_valid_o,
  output b64_pkg::res_t res_o,
  input  logic          res_full_i
);
  import b64_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       final_beat;
  logic       fire;

  // Encode jobs take four beats, all others one
  assign final_beat  = (job_i.kind != JOB_ENC) || (idx_q == 2'd3);
  assign fire        = job_valid_i && !res_full_i;
  assign res_valid_o = fire;
  assign job_pop_o   = fire && final_beat;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = final_beat ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // Form the result beat
  always_comb begin
    res_o.data     = '0;
    res_o.has_data = 1'b0;
    res_o.bad_char = 1'b0;
    res_o.last     = 1'b0;
    case (job_i.kind)
      JOB_ENC: begin
        res_o.has_data = 1'b1;
        case (idx_q)
          2'd0: res_o.data = b64_char(job_i.group[23:18]);
          2'd1: res_o.data = b64_char(job_i.group[17:12]);
          2'd2: res_o.data = (job_i.nbytes >= 2'd2) ? b64_char(job_i.group[11:6]) : CHAR_PAD;
          default: begin
            res_o.data = (job_i.nbytes == 2'd3) ? b64_char(job_i.group[5:0]) : CHAR_PAD;
            res_o.last = job_i.last;
          end
        endcase
      end
      JOB_DATA: begin
        res_o.data     = job_i.group[7:0];
        res_o.has_data = 1'b1;
        res_o.last     = job_i.last;
      end
      JOB_ERR: begin
        res_o.bad_char = 1'b1;
        res_o.last     = 1'b1;
      end
      default: begin
        res_o.last = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/base64_codec.sv =====
// The first result beat of an item is registered in the job queue and then in the result
// queue; the remaining beats of an encode group follow one per cycle while that queue has room.
// The block takes one input beat per cycle while the job queue has room; the back stage
// writes one result per cycle while the result queue has room, four beats per encode group.
// Reset: rst_ni clears direction to encode, all codec state and both queues.
// Top level of the base64 codec: config register, front, back and queues.
`default_nettype none

module base64_codec #(
  parameter int unsigned JobDepth = b64_pkg::JOB_DEPTH,
  parameter int unsigned ResDepth = b64_pkg::RES_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input queue side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  // Result queue side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        has_data_o,
  output logic        bad_char_o,
  output logic        out_last_o
);
  import b64_pkg::*;

  localparam int unsigned JobW = $bits(job_t);
  localparam int unsigned ResW = $bits(res_t);

  dir_e        direction_q, direction_d;
  logic        front_valid;
  logic        job_push;
  job_t        job_in, job_head;
  logic [JobW-1:0] job_head_raw;
  logic        job_empty, job_pop;
  logic        res_push, res_full;
  res_t        res_in, res_head;
  logic [ResW-1:0] res_head_raw;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DIRECTION) ? {31'd0, direction_q} : 32'd0;

  always_comb begin
    direction_d = direction_q;
    if (psel && penable && pwrite && pready && paddr[2] == REG_DIRECTION) begin
      direction_d = dir_e'(pwdata[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= DIR_ENC;
    end else begin
      direction_q <= direction_d;
    end
  end

  // Accept a beat whenever the job queue has room
  assign front_valid = push && !full;

  b64_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (front_valid),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .dir_i      (direction_q),
    .job_valid_o(job_push),
    .job_o      (job_in)
  );

  b64_fifo #(
    .Width(JobW),
    .Depth(JobDepth)
  ) u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (job_pop),
    .data_o (job_head_raw),
    .empty_o(job_empty)
  );

  assign job_head = job_t'(job_head_raw);

  b64_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!job_empty),
    .job_i      (job_head),
    .job_pop_o  (job_pop),
    .res_valid_o(res_push),
    .res_o      (res_in),
    .res_full_i (res_full)
  );

  b64_fifo #(
    .Width(ResW),
    .Depth(ResDepth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_head_raw),
    .empty_o(empty)
  );

  // Drive the result ports from the queue head
  assign res_head   = res_t'(res_head_raw);
  assign out_byte_o = res_head.data;
  assign has_data_o = res_head.has_data;
  assign bad_char_o = res_head.bad_char;
  assign out_last_o = res_head.last;

  // Checks
`include "base64_codec_macros.svh"

  `B64_ASSERT(a_bad_closes, !empty && bad_char_o |-> !has_data_o && out_last_o, "error beat must close the message without data")
  `B64_ASSERT(a_marker_zero, !empty && !has_data_o |-> out_byte_o == 8'h00, "marker beat carries nonzero byte")
  `B64_ASSERT(a_enc_last_job, push && !full && direction_q == DIR_ENC && in_last_i |=> !job_empty, "encode last beat left no job")

endmodule

`default_nettype wire

// ===== test/codec_scoreboard_pkg.sv =====
// Scoreboard for the base64 codec: predicts result beats and checks them in order.
package codec_scoreboard_pkg;

  import b64_pkg::*;

  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  class codec_scoreboard;
    dir_e        dir;
    logic [15:0] enc_hold;
    logic [1:0]  enc_cnt;
    logic [12:0] dec_acc;
    int          dec_bits;
    bit          skip_rest;
    res_t        expected_q[$];
    int          errors;
    int          n_in;
    int          n_ignored;
    int          n_out;
    int          n_pad;
    int          n_bad;
    int          n_end;

    function new();
      dir       = DIR_ENC;
      enc_hold  = '0;
      enc_cnt   = '0;
      dec_acc   = '0;
      dec_bits  = 0;
      skip_rest = 1'b0;
    endfunction

    function void set_direction(dir_e d);
      dir = d;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    function void expect_beat(logic [7:0] d, logic hd, logic bc, logic l);
      res_t r;
      r.data     = d;
      r.has_data = hd;
      r.bad_char = bc;
      r.last     = l;
      expected_q.push_back(r);
    endfunction

    function logic [7:0] char_of(logic [5:0] idx);
      return B64_ALPHABET[idx];
    endfunction

    // 0..63 for alphabet characters, 64 for skipped ones, 65 for anything else
    function int value_of(logic [7:0] c);
      for (int i = 0; i < 64; i++) begin
        if (B64_ALPHABET[i] == c) return i;
      end
      if (c == CHAR_CR || c == CHAR_LF || c == CHAR_SPACE || c == CHAR_PAD) return 64;
      return 65;
    endfunction

    // Note one accepted input beat; return 1 when the codec ignores it
    function bit note_beat(logic [7:0] b, logic last);
      int          n;
      int          v;
      int          nb;
      logic [23:0] grp;
      logic [7:0]  c2;
      logic [7:0]  c3;
      n_in++;
      if (dir == DIR_ENC) begin
        // hold bytes until a group is full or the message ends
        if (!last && enc_cnt < 2) begin
          enc_hold = {enc_hold[7:0], b};
          enc_cnt++;
          return 1'b0;
        end
        n   = int'(enc_cnt) + 1;
        grp = {enc_hold, b};
        grp = grp << (8 * (3 - n));
        c2  = (n >= 2) ? char_of(grp[11:6]) : CHAR_PAD;
        c3  = (n >= 3) ? char_of(grp[5:0]) : CHAR_PAD;
        if (n < 3) n_pad++;
        expect_beat(char_of(grp[23:18]), 1'b1, 1'b0, 1'b0);
        expect_beat(char_of(grp[17:12]), 1'b1, 1'b0, 1'b0);
        expect_beat(c2, 1'b1, 1'b0, 1'b0);
        expect_beat(c3, 1'b1, 1'b0, last);
        enc_hold = '0;
        enc_cnt  = '0;
        if (last) skip_rest = 1'b0;
        return 1'b0;
      end
      // drop everything after a decode error up to the end of the message
      if (skip_rest) begin
        if (last) skip_rest = 1'b0;
        n_ignored++;
        return 1'b1;
      end
      v = value_of(b);
      if (v == 65) begin
        expect_beat(8'h00, 1'b0, 1'b1, 1'b1);
        n_bad++;
        dec_acc   = '0;
        dec_bits  = 0;
        skip_rest = !last;
        return 1'b0;
      end
      if (v < 64) begin
        nb      = dec_bits + 6;
        dec_acc = {dec_acc[6:0], 6'(v)};
        if (nb >= 8) begin
          nb -= 8;
          expect_beat(8'(dec_acc >> nb), 1'b1, 1'b0, last);
          dec_bits = nb;
          if (last) begin
            dec_acc  = '0;
            dec_bits = 0;
          end
          return 1'b0;
        end
        dec_bits = nb;
      end
      // close the message with a bare end marker when no byte came out
      if (last) begin
        expect_beat(8'h00, 1'b0, 1'b0, 1'b1);
        n_end++;
        dec_acc  = '0;
        dec_bits = 0;
      end
      return 1'b0;
    endfunction

    // Compare one accepted result beat with the oldest prediction
    function void check_beat(res_t got);
      res_t want;
      n_out++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing predicted", n_out));
        return;
      end
      want = expected_q.pop_front();
      if (got.data !== want.data)
        report($sformatf("result %0d out_byte: want %h got %h", n_out, want.data, got.data));
      if (got.has_data !== want.has_data)
        report($sformatf("result %0d has_data: want %b got %b", n_out, want.has_data,
                         got.has_data));
      if (got.bad_char !== want.bad_char)
        report($sformatf("result %0d bad_char: want %b got %b", n_out, want.bad_char,
                         got.bad_char));
      if (got.last !== want.last)
        report($sformatf("result %0d out_last: want %b got %b", n_out, want.last, got.last));
    endfunction
  endclass

endpackage

// ===== test/tb_top.sv =====
// Top-level testbench of the base64 codec: drives beats and the direction register.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b64_pkg::*;
  import codec_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 150;
  localparam logic [2:0] DIR_ADDR = {REG_DIRECTION, 2'b00};

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push      = 1'b0;
  logic        full;
  logic [7:0]  in_byte_i = '0;
  logic        in_last_i = 1'b0;
  logic        empty;
  logic        pop       = 1'b0;
  logic [7:0]  out_byte_o;
  logic        has_data_o;
  logic        bad_char_o;
  logic        out_last_o;

  codec_scoreboard sb = new();

  int live_items = 0;
  int cfg_writes = 0;
  int cycles     = 0;
  bit src_quiet  = 1'b0;
  bit sink_quiet = 1'b0;

  base64_codec u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .has_data_o (has_data_o),
    .bad_char_o (bad_char_o),
    .out_last_o (out_last_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Pop result beats with random stalls and check each one
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        sb.check_beat('{data: out_byte_o, has_data: has_data_o, bad_char: bad_char_o,
                        last: out_last_o});
        hold = sink_quiet ? 0 : $urandom_range(0, 11);
      end else if (hold > 0) begin
        hold--;
      end
      pop <= (hold == 0);
    end
  end

  // Push one input beat after a random gap; called at a rising edge
  task automatic send_beat(logic [7:0] b, logic last);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_byte_i <= b;
    in_last_i <= last;
    push      <= 1'b1;
    do @(posedge clk_i); while (full);
    if (!sb.note_beat(b, last)) live_items++;
  endtask

  // Push a string one character per beat, last on the final one if asked
  task automatic send_text(string s, bit close);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], close && (i == s.len() - 1));
    end
  endtask

  // Hold input until every predicted result has come, then let the pipe settle
  task automatic drain_results();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the direction register, then read it back
  task automatic write_direction(dir_e d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DIR_ADDR;
    pwdata  <= 32'(d);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_direction(d);
    cfg_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== d)
      sb.report($sformatf("direction read back %b, wrote %b", prdata[0], d));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly alphabet characters, some skipped ones, a few arbitrary bytes
  function automatic logic [7:0] pick_text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return B64_ALPHABET[$urandom_range(0, 63)];
    if (r < 92) begin
      case ($urandom_range(0, 3))
        0: return CHAR_CR;
        1: return CHAR_LF;
        2: return CHAR_SPACE;
        default: return CHAR_PAD;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    int   random_start;
    int   len;
    bit   close;
    logic last;
    logic [7:0] b;
    dir_e d;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Encode: full group, one-byte and two-byte tails, then a byte left held
    write_direction(DIR_ENC);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h01, 1'b1);
    send_beat(8'hFB, 1'b0);
    send_beat(8'h7F, 1'b1);
    send_beat(8'h4D, 1'b0);

    // Decode with the encoder still holding a byte
    drain_results();
    write_direction(DIR_DEC);
    send_text("+/\r\n9z", 1'b1);
    send_text("A =", 1'b1);
    send_text("Q*", 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    send_text("a#", 1'b0);

    // Encode last flushes the held byte and clears the decode error state
    drain_results();
    write_direction(DIR_ENC);
    send_beat(8'h61, 1'b1);
    drain_results();
    write_direction(DIR_DEC);
    send_text("TQ=", 1'b1);

    // Random messages, each phase at a fresh direction setting
    random_start = live_items;
    while (live_items - random_start < RANDOM_ITEMS) begin
      drain_results();
      d = $urandom_range(0, 1) ? DIR_DEC : DIR_ENC;
      write_direction(d);
      src_quiet  = ($urandom_range(0, 4) == 0);
      sink_quiet = ($urandom_range(0, 4) == 0);
      close = ($urandom_range(0, 7) != 0);
      len   = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        b    = (d == DIR_ENC) ? 8'($urandom_range(0, 255)) : pick_text_char();
        last = (close && k == len - 1) || ($urandom_range(0, 19) == 0);
        send_beat(b, last);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Covered %0d input beats (%0d dropped after decode errors), %0d result beats,",
             sb.n_in, sb.n_ignored, sb.n_out);
    $display("%0d direction writes, %0d padded encode groups, %0d invalid-character markers, %0d bare end markers.",
             cfg_writes, sb.n_pad, sb.n_bad, sb.n_end);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/b64_pkg.sv
hw/rtl/b64_fifo.sv
hw/rtl/b64_front.sv
hw/rtl/b64_back.sv
hw/rtl/base64_codec.sv
test/codec_scoreboard_pkg.sv
test/tb_top.sv
